// ===== hdl/sjfk_pkg.sv =====
// Shared widths, fixed-point types and rounding helpers for the six-joint kinematics pipeline.
package sjfk_pkg;

    // Field widths at the ports
    localparam int ANG_W  = 16;
    localparam int LEN_W  = 17;
    localparam int ROT_W  = 16;
    localparam int POS_W  = 18;
    localparam int IDX_W  = 3;

    // Link-length register indexes
    localparam logic [IDX_W-1:0] REG_UPPER_ARM   = 3'd0;
    localparam logic [IDX_W-1:0] REG_FOREARM     = 3'd1;
    localparam logic [IDX_W-1:0] REG_BASE_HEIGHT = 3'd2;
    localparam logic [IDX_W-1:0] REG_SHOULDER    = 3'd3;
    localparam logic [IDX_W-1:0] REG_WRIST_TWO   = 3'd4;
    localparam logic [IDX_W-1:0] REG_WRIST_THREE = 3'd5;

    // Internal Q28 formats
    localparam int FRAC    = 28;
    localparam int UNIT_W  = 30;
    localparam int POSQ_W  = 34;
    localparam int ACC_W   = 72;

    typedef logic signed [ANG_W-1:0]           angle_t;
    typedef logic signed [LEN_W-1:0]           len_t;
    typedef logic signed [ROT_W-1:0]           rot_t;
    typedef logic signed [POS_W-1:0]           pos_t;
    typedef logic signed [UNIT_W-1:0]          unit_t;
    typedef logic signed [POSQ_W-1:0]          posq_t;
    typedef logic signed [ACC_W-1:0]           acc_t;
    typedef logic signed [2*UNIT_W-1:0]        prod_t;
    typedef logic signed [UNIT_W+POSQ_W-1:0]   pprod_t;

    localparam unit_t ONE_Q = 30'sd268435456;

    // One homogeneous transform: row-major rotation and position
    typedef struct packed {
        unit_t [8:0] r;
        posq_t [2:0] p;
    } frame_t;

    // Round to nearest, ties away from zero, then drop sh fraction bits
    function automatic acc_t rnd_sh(input acc_t v, input int sh);
        acc_t half;
        half = acc_t'(1) <<< (sh - 1);
        if (v[ACC_W-1])
            return (v + half - acc_t'(1)) >>> sh;
        return (v + half) >>> sh;
    endfunction

    // Full-precision product of two Q28 unit values
    function automatic acc_t mul_uu(input unit_t a, input unit_t b);
        prod_t p;
        p = a * b;
        return acc_t'(p);
    endfunction

endpackage

// ===== hdl/sjfk_sincos.sv =====
// Pipelined sine and cosine of one joint angle: quadrant reduction and Taylor polynomials.
module sjfk_sincos (
    input  logic            clk,
    input  logic            adv,
    input  sjfk_pkg::angle_t angle,
    output sjfk_pkg::unit_t  sin_q,
    output sjfk_pkg::unit_t  cos_q
);
    import sjfk_pkg::*;

    localparam int ITER  = 4;
    localparam int DEPTH = 2 * ITER + 1;

    localparam logic signed [33:0] HALF_PI_Q    = 34'sd421657428;
    localparam logic signed [33:0] QUARTER_PI_Q = 34'sd210828714;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Reciprocals for exact truncating division of values below 2^28
    localparam int SIN_SH [0:ITER-1] = '{36, 35, 34, 32};
    localparam int COS_SH [0:ITER-1] = '{36, 35, 34, 33};
    localparam logic [UNIT_W-1:0] SIN_RCP [0:ITER-1] = '{
        UNIT_W'(((64'd1 << 36) + 64'd71) / 64'd72),
        UNIT_W'(((64'd1 << 35) + 64'd41) / 64'd42),
        UNIT_W'(((64'd1 << 34) + 64'd19) / 64'd20),
        UNIT_W'(((64'd1 << 32) + 64'd5) / 64'd6)
    };
    localparam logic [UNIT_W-1:0] COS_RCP [0:ITER-1] = '{
        UNIT_W'(((64'd1 << 36) + 64'd89) / 64'd90),
        UNIT_W'(((64'd1 << 35) + 64'd55) / 64'd56),
        UNIT_W'(((64'd1 << 34) + 64'd29) / 64'd30),
        UNIT_W'(((64'd1 << 33) + 64'd11) / 64'd12)
    };

    logic signed [31:0] a_next, a_reg;
    logic signed [33:0] t_next;
    logic [3:0]         cnt_next;
    logic signed [3:0]  k_reg;
    unit_t              rs_reg;
    logic [1:0]         q_reg  [0:DEPTH+1];
    unit_t              rr_reg [0:DEPTH-1];
    unit_t              sq_reg [0:DEPTH-1];
    unit_t              xs_reg [0:ITER-1];
    unit_t              xc_reg [0:ITER-1];
    unit_t              ts_reg [0:ITER-1];
    unit_t              tc_reg [0:ITER-1];
    unit_t              ts_in  [0:ITER-1];
    unit_t              tc_in  [0:ITER-1];
    unit_t              ts_next [0:ITER-1];
    unit_t              tc_next [0:ITER-1];
    unit_t              s_reg, c_reg, c_half;
    unit_t              sin_reg, cos_reg;

    // Count the quarter turns crossed by the shifted angle
    always_comb
    begin
        a_next   = {angle, 16'h0000};
        t_next   = 34'(a_next) + QUARTER_PI_Q;
        cnt_next = 4'd0;
        for (int m = -4; m <= 5; m++)
        begin
            if (t_next >= 34'(m) * HALF_PI_Q)
                cnt_next = cnt_next + 4'd1;
        end
    end

    // Feed each polynomial step and divide by its constant
    always_comb
    begin
        logic [2*UNIT_W-1:0] qs;
        logic [2*UNIT_W-1:0] qc;
        logic [UNIT_W-1:0]   xsu;
        logic [UNIT_W-1:0]   xcu;
        for (int i = 0; i < ITER; i++)
        begin
            if (i == 0)
            begin
                ts_in[i] = ONE_Q;
                tc_in[i] = ONE_Q;
            end
            else
            begin
                ts_in[i] = ts_reg[(i == 0) ? 0 : i - 1];
                tc_in[i] = tc_reg[(i == 0) ? 0 : i - 1];
            end
            xsu        = xs_reg[i];
            xcu        = xc_reg[i];
            qs         = xsu * SIN_RCP[i];
            qc         = xcu * COS_RCP[i];
            qs         = qs >> SIN_SH[i];
            qc         = qc >> COS_SH[i];
            ts_next[i] = ONE_Q - unit_t'(qs[UNIT_W-1:0]);
            tc_next[i] = ONE_Q - unit_t'(qc[UNIT_W-1:0]);
        end
        c_half = unit_t'(rnd_sh(mul_uu(sq_reg[DEPTH-1], tc_reg[ITER-1]), FRAC)) >>> 1;
    end

    // Advance every stage together
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg     <= a_next;
            k_reg     <= 4'(cnt_next - 4'd5);
            rs_reg    <= unit_t'(34'(a_reg) - 34'(k_reg) * HALF_PI_Q);
            q_reg[0]  <= k_reg[1:0];
            rr_reg[0] <= rs_reg;
            sq_reg[0] <= unit_t'(rnd_sh(mul_uu(rs_reg, rs_reg), FRAC));
            q_reg[1]  <= q_reg[0];
            for (int n = 1; n < DEPTH; n++)
            begin
                rr_reg[n]    <= rr_reg[n-1];
                sq_reg[n]    <= sq_reg[n-1];
                q_reg[n+1]   <= q_reg[n];
            end
            for (int i = 0; i < ITER; i++)
            begin
                xs_reg[i] <= unit_t'(rnd_sh(mul_uu(sq_reg[2*i], ts_in[i]), FRAC));
                xc_reg[i] <= unit_t'(rnd_sh(mul_uu(sq_reg[2*i], tc_in[i]), FRAC));
                ts_reg[i] <= ts_next[i];
                tc_reg[i] <= tc_next[i];
            end
            s_reg          <= unit_t'(rnd_sh(mul_uu(rr_reg[DEPTH-1], ts_reg[ITER-1]), FRAC));
            c_reg          <= ONE_Q - c_half;
            q_reg[DEPTH+1] <= q_reg[DEPTH];
            // Fold the quadrant back in
            case (q_reg[DEPTH+1])
                QUAD_0:
                begin
                    sin_reg <= s_reg;
                    cos_reg <= c_reg;
                end
                QUAD_1:
                begin
                    sin_reg <= c_reg;
                    cos_reg <= -s_reg;
                end
                QUAD_2:
                begin
                    sin_reg <= -s_reg;
                    cos_reg <= -c_reg;
                end
                QUAD_3:
                begin
                    sin_reg <= -c_reg;
                    cos_reg <= s_reg;
                end
                default:
                begin
                    sin_reg <= s_reg;
                    cos_reg <= c_reg;
                end
            endcase
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

// ===== hdl/six_joint_forward_kinematics.sv =====
// Throughput: one pose per cycle unless the result beat is stalled; the 13-stage
// sine/cosine pipeline, five two-stage link products and an output rounding stage
// all advance together.
// A stalled result beat freezes the whole pipeline, so nothing is lost or repeated.
// Reset clears the valid bits and loads the default link lengths.
// Top level of the six-joint forward kinematics pipeline.
module six_joint_forward_kinematics (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pose_valid,
    output logic              pose_stall,
    input  sjfk_pkg::angle_t  base_angle,
    input  sjfk_pkg::angle_t  shoulder_angle,
    input  sjfk_pkg::angle_t  elbow_angle,
    input  sjfk_pkg::angle_t  wrist_one_angle,
    input  sjfk_pkg::angle_t  wrist_two_angle,
    input  sjfk_pkg::angle_t  wrist_three_angle,
    output logic              result_valid,
    input  logic              result_stall,
    output sjfk_pkg::rot_t    rot_r0c0,
    output sjfk_pkg::rot_t    rot_r0c1,
    output sjfk_pkg::rot_t    rot_r0c2,
    output sjfk_pkg::rot_t    rot_r1c0,
    output sjfk_pkg::rot_t    rot_r1c1,
    output sjfk_pkg::rot_t    rot_r1c2,
    output sjfk_pkg::rot_t    rot_r2c0,
    output sjfk_pkg::rot_t    rot_r2c1,
    output sjfk_pkg::rot_t    rot_r2c2,
    output sjfk_pkg::pos_t    pos_x,
    output sjfk_pkg::pos_t    pos_y,
    output sjfk_pkg::pos_t    pos_z,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [sjfk_pkg::IDX_W-1:0] cfg_index,
    input  sjfk_pkg::len_t    cfg_data
);
    import sjfk_pkg::*;

    localparam int NUM_LEN = 6;
    localparam int NUM_JNT = 6;
    localparam int LAT     = 24;
    localparam int ROT_SH  = 14;
    localparam int POS_SH  = 12;
    localparam int LEN_SH  = 12;

    localparam len_t LEN_RESET [0:NUM_LEN-1] = '{
        -17'sd27853, -17'sd25703, 17'sd10650, 17'sd8736, 17'sd6534, 17'sd6527
    };

    // Link forms: joint about z, x twisted by plus or minus a quarter turn
    localparam logic [1:0] FORM_Z  = 2'd0;
    localparam logic [1:0] FORM_XP = 2'd1;
    localparam logic [1:0] FORM_XN = 2'd2;

    localparam rot_t ROT_MAX = 16'sd16384;
    localparam rot_t ROT_MIN = -16'sd16384;
    localparam pos_t POS_MAX = 18'sd131071;
    localparam pos_t POS_MIN = -18'sd131072;

    typedef struct packed {
        prod_t  [2:0] pa;
        prod_t  [2:0] pb;
        prod_t  [2:0] pc;
        prod_t  [2:0] pd;
        unit_t  [2:0] w;
        posq_t  [2:0] ap;
        pprod_t [2:0] px;
        pprod_t [2:0] py;
        pprod_t [2:0] pz;
    } prd_t;

    function automatic posq_t len_q(input len_t l);
        return posq_t'(l) <<< LEN_SH;
    endfunction

    function automatic rot_t sat_rot(input acc_t v);
        if (v > acc_t'(ROT_MAX))
            return ROT_MAX;
        if (v < acc_t'(ROT_MIN))
            return ROT_MIN;
        return rot_t'(v);
    endfunction

    function automatic pos_t sat_pos(input acc_t v);
        if (v > acc_t'(POS_MAX))
            return POS_MAX;
        if (v < acc_t'(POS_MIN))
            return POS_MIN;
        return pos_t'(v);
    endfunction

    logic   adv;
    logic   vld_reg [1:LAT];
    len_t   len_reg [0:NUM_LEN-1];
    angle_t d2_reg [0:1];
    angle_t d3_reg [0:3];
    angle_t d4_reg [0:5];
    angle_t d5_reg [0:7];
    angle_t sc_ang [0:NUM_JNT-1];
    unit_t  sin_w  [0:NUM_JNT-1];
    unit_t  cos_w  [0:NUM_JNT-1];
    frame_t frame0;
    frame_t fr_in   [1:5];
    frame_t fr_next [1:5];
    frame_t fr_reg  [1:5];
    prd_t   prd_next [1:5];
    prd_t   prd_reg  [1:5];
    posq_t  ox [1:5];
    posq_t  oy [1:5];
    posq_t  oz [1:5];
    rot_t   rot_reg [0:8];
    pos_t   pos_reg [0:2];

    // Whole pipeline moves unless a finished beat is held
    assign adv          = !vld_reg[LAT] || !result_stall;
    assign pose_stall   = !adv;
    assign result_valid = vld_reg[LAT];
    assign cfg_ready    = 1'b1;

    // Take link-length writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LEN; i++)
                len_reg[i] <= LEN_RESET[i];
        end
        else if (cfg_valid && (cfg_index < IDX_W'(NUM_LEN)))
        begin
            len_reg[cfg_index] <= cfg_data;
        end
    end

    // Carry valid bits along with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 1; n <= LAT; n++)
                vld_reg[n] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[1] <= pose_valid;
            for (int n = 2; n <= LAT; n++)
                vld_reg[n] <= vld_reg[n-1];
        end
    end

    // Hold later joints back until their link product comes up
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d2_reg[0] <= elbow_angle;
            d3_reg[0] <= wrist_one_angle;
            d4_reg[0] <= wrist_two_angle;
            d5_reg[0] <= wrist_three_angle;
            d2_reg[1] <= d2_reg[0];
            for (int n = 1; n < 4; n++)
                d3_reg[n] <= d3_reg[n-1];
            for (int n = 1; n < 6; n++)
                d4_reg[n] <= d4_reg[n-1];
            for (int n = 1; n < 8; n++)
                d5_reg[n] <= d5_reg[n-1];
        end
    end

    assign sc_ang[0] = base_angle;
    assign sc_ang[1] = shoulder_angle;
    assign sc_ang[2] = d2_reg[1];
    assign sc_ang[3] = d3_reg[3];
    assign sc_ang[4] = d4_reg[5];
    assign sc_ang[5] = d5_reg[7];

    for (genvar j = 0; j < NUM_JNT; j++)
    begin : g_sc
        sjfk_sincos u_sincos (
            .clk   (clk),
            .adv   (adv),
            .angle (sc_ang[j]),
            .sin_q (sin_w[j]),
            .cos_q (cos_w[j])
        );
    end

    // Build the base transform and the link offsets
    always_comb
    begin
        frame0.r[0] = cos_w[0];
        frame0.r[1] = -sin_w[0];
        frame0.r[2] = '0;
        frame0.r[3] = sin_w[0];
        frame0.r[4] = cos_w[0];
        frame0.r[5] = '0;
        frame0.r[6] = '0;
        frame0.r[7] = '0;
        frame0.r[8] = ONE_Q;
        frame0.p[0] = '0;
        frame0.p[1] = '0;
        frame0.p[2] = len_q(len_reg[REG_BASE_HEIGHT]);
        for (int j = 1; j <= 5; j++)
        begin
            ox[j] = '0;
            oy[j] = '0;
            oz[j] = '0;
        end
        ox[2] = len_q(len_reg[REG_UPPER_ARM]);
        ox[3] = len_q(len_reg[REG_FOREARM]);
        oz[3] = len_q(len_reg[REG_SHOULDER]);
        oy[4] = -len_q(len_reg[REG_WRIST_TWO]);
        oy[5] = len_q(len_reg[REG_WRIST_THREE]);
        fr_in[1] = frame0;
        for (int j = 2; j <= 5; j++)
            fr_in[j] = fr_reg[j-1];
    end

    // Multiply stage of each link product
    always_comb
    begin
        unit_t      a0;
        unit_t      a1;
        unit_t      a2;
        unit_t      u;
        unit_t      wv;
        logic [1:0] form;
        for (int j = 1; j <= 5; j++)
        begin
            case (j)
                1:       form = FORM_XP;
                4:       form = FORM_XP;
                5:       form = FORM_XN;
                default: form = FORM_Z;
            endcase
            for (int i = 0; i < 3; i++)
            begin
                a0 = fr_in[j].r[3*i];
                a1 = fr_in[j].r[3*i+1];
                a2 = fr_in[j].r[3*i+2];
                case (form)
                    FORM_XP:
                    begin
                        u  = a2;
                        wv = -a1;
                    end
                    FORM_XN:
                    begin
                        u  = -a2;
                        wv = a1;
                    end
                    default:
                    begin
                        u  = a1;
                        wv = a2;
                    end
                endcase
                prd_next[j].pa[i] = a0 * cos_w[j];
                prd_next[j].pb[i] = u * sin_w[j];
                prd_next[j].pc[i] = a0 * sin_w[j];
                prd_next[j].pd[i] = u * cos_w[j];
                prd_next[j].w[i]  = wv;
                prd_next[j].ap[i] = fr_in[j].p[i];
                prd_next[j].px[i] = a0 * ox[j];
                prd_next[j].py[i] = a1 * oy[j];
                prd_next[j].pz[i] = a2 * oz[j];
            end
        end
    end

    // Sum, round and offset stage of each link product
    always_comb
    begin
        for (int j = 1; j <= 5; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                fr_next[j].r[3*i] = unit_t'(rnd_sh(acc_t'(prd_reg[j].pa[i])
                    + acc_t'(prd_reg[j].pb[i]), FRAC));
                fr_next[j].r[3*i+1] = unit_t'(rnd_sh(acc_t'(prd_reg[j].pd[i])
                    - acc_t'(prd_reg[j].pc[i]), FRAC));
                fr_next[j].r[3*i+2] = prd_reg[j].w[i];
                fr_next[j].p[i] = posq_t'(rnd_sh(acc_t'(prd_reg[j].px[i])
                    + acc_t'(prd_reg[j].py[i]) + acc_t'(prd_reg[j].pz[i]), FRAC))
                    + prd_reg[j].ap[i];
            end
        end
    end

    // Advance the link products and round the result beat
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 1; j <= 5; j++)
            begin
                prd_reg[j] <= prd_next[j];
                fr_reg[j]  <= fr_next[j];
            end
            for (int n = 0; n < 9; n++)
                rot_reg[n] <= sat_rot(rnd_sh(acc_t'(fr_reg[5].r[n]), ROT_SH));
            for (int n = 0; n < 3; n++)
                pos_reg[n] <= sat_pos(rnd_sh(acc_t'(fr_reg[5].p[n]), POS_SH));
        end
    end

    assign rot_r0c0 = rot_reg[0];
    assign rot_r0c1 = rot_reg[1];
    assign rot_r0c2 = rot_reg[2];
    assign rot_r1c0 = rot_reg[3];
    assign rot_r1c1 = rot_reg[4];
    assign rot_r1c2 = rot_reg[5];
    assign rot_r2c0 = rot_reg[6];
    assign rot_r2c1 = rot_reg[7];
    assign rot_r2c2 = rot_reg[8];
    assign pos_x    = pos_reg[0];
    assign pos_y    = pos_reg[1];
    assign pos_z    = pos_reg[2];

endmodule
